/* design/hdlc_pkg.sv */
// Package for the HDLC bit unstuffing deframer core.
// Holds counter sizes, register indexes, record and status codes and the result record type.
// Depends on nothing; every design file imports it.
package hdlc_pkg;

    // Width of the frame byte counter.
    localparam int COUNT_WIDTH = 10;
    // Width of the configuration registers and of the index and length fields.
    localparam int REG_WIDTH   = 10;
    // Common width for comparing the byte counter against a register.
    localparam int CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

    // Line constants.
    localparam logic [2:0] STUFF_RUN = 3'd5;
    localparam logic [2:0] RUN_SAT   = 3'd7;
    localparam logic [2:0] LAST_BIT  = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [REG_WIDTH-1:0] MIN_FRAME_RESET = REG_WIDTH'(32);
    localparam logic [REG_WIDTH-1:0] MAX_FRAME_RESET = REG_WIDTH'(500);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MIN_FRAME = 2'd0,
        REG_MAX_FRAME = 2'd1
    } reg_index_t;

    // Kind of an output record.
    typedef enum logic [0:0] {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } record_kind_t;

    // Status carried by a frame end record.
    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_ABORTED  = 2'd2
    } frame_status_t;

    // One output record.
    typedef struct packed {
        record_kind_t           record_kind;
        logic [7:0]             data_byte;
        logic [REG_WIDTH-1:0]   byte_index;
        logic [REG_WIDTH-1:0]   frame_length;
        frame_status_t          frame_status;
    } record_t;

endpackage

/* design/hdlc_bit_unstuff_deframer_core.sv */
// Top level of the HDLC bit unstuffing deframer core.
// Unstuffs received line bits, assembles bytes and reports frame ends.
// Depends on hdlc_pkg.
//
// Usage:
// - Slave stream (s_axis_*) takes one received line bit per transfer in
//   s_axis_tdata[0]; the other tdata bits are ignored.
// - Master stream (m_axis_*) gives at most one record per input bit.
//   m_axis_tuser is the record kind (data byte or frame end); m_axis_tdata
//   carries the byte, its index, the frame length and the frame status.
// - Configuration channel (cfg_*) writes the minimum and maximum frame
//   length; it is always ready and is meant to be used while the core is idle.
// Timing:
// - One bit is accepted every cycle while s_axis_tready is high. The deframing
//   state is updated in the cycle of the transfer and the record is registered.
// - An output register and a skid register follow the state logic, so the
//   core keeps taking bits while one record waits; s_axis_tready drops only
//   when both are full, and rises again as soon as the receiver takes one.
// - Reset clears all counters and the valid flags of the record buffers and
//   loads the default limits of 32 and 500 bytes.
module hdlc_bit_unstuff_deframer_core
    import hdlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Line bit input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] line_bit, [7:1] zero
    // Record output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [7:0] data_byte, [17:8] byte_index,
                                                 // [27:18] frame_length,
                                                 // [29:28] frame_status, [31:30] zero
    output logic                 m_axis_tuser,   // [0] record_kind
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [REG_WIDTH-1:0] cfg_data
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = {COUNT_WIDTH{1'b1}};

    // Configuration registers.
    logic [REG_WIDTH-1:0]   min_frame_reg;
    logic [REG_WIDTH-1:0]   max_frame_reg;

    // Deframing state.
    logic [2:0]             ones_run_reg,   ones_run_next;
    logic [2:0]             bit_count_reg,  bit_count_next;
    logic [COUNT_WIDTH-1:0] byte_count_reg, byte_count_next;
    logic [7:0]             shift_byte_reg, shift_byte_next;

    // Record buffers.
    logic                   out_valid_reg,  out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    record_t                out_rec_reg,    out_rec_next;
    record_t                skid_rec_reg,   skid_rec_next;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   line_bit;
    logic                   run_full;
    logic                   over_max;
    logic                   rec_emit;
    record_t                rec;
    logic [7:0]             shifted;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign line_bit      = s_axis_tdata[0];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_frame_reg <= MIN_FRAME_RESET;
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MIN_FRAME)
            begin
                min_frame_reg <= cfg_data;
            end
            else if (cfg_index == REG_MAX_FRAME)
            begin
                max_frame_reg <= cfg_data;
            end
        end
    end

    // Frame overrun: above the maximum, or counter full so it never wraps.
    assign run_full = (ones_run_reg >= STUFF_RUN);
    assign over_max = (CMP_WIDTH'(byte_count_reg) > CMP_WIDTH'(max_frame_reg))
                      || (byte_count_reg == COUNT_FULL);
    assign shifted  = {line_bit, shift_byte_reg[7:1]};

    // Unstuffing, flag detection and byte assembly for one bit.
    always_comb
    begin
        ones_run_next   = ones_run_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        shift_byte_next = shift_byte_reg;
        rec_emit        = 1'b0;
        rec             = '{record_kind: KIND_END, data_byte: 8'd0,
                            byte_index: '0, frame_length: '0,
                            frame_status: STATUS_ACCEPTED};
        rec.frame_length = REG_WIDTH'(byte_count_reg);

        if (in_xfer)
        begin
            if (run_full)
            begin
                // A one after five ones is a flag; a zero is a stuffed bit.
                if (line_bit)
                begin
                    if (byte_count_reg != '0)
                    begin
                        rec_emit = 1'b1;
                        if (over_max)
                        begin
                            rec.frame_status = STATUS_ABORTED;
                        end
                        else if (CMP_WIDTH'(byte_count_reg) >= CMP_WIDTH'(min_frame_reg))
                        begin
                            rec.frame_status = STATUS_ACCEPTED;
                        end
                        else
                        begin
                            rec.frame_status = STATUS_SHORT;
                        end
                    end
                    bit_count_next  = '0;
                    byte_count_next = '0;
                    shift_byte_next = '0;
                end
            end
            else if (over_max)
            begin
                // Abort an overlong frame.
                rec_emit         = 1'b1;
                rec.frame_status = STATUS_ABORTED;
                bit_count_next   = '0;
                byte_count_next  = '0;
                shift_byte_next  = '0;
            end
            else
            begin
                // Data bit, first bit ends in the least significant position.
                shift_byte_next = shifted;
                bit_count_next  = bit_count_reg + 3'd1;
                if (bit_count_reg == LAST_BIT)
                begin
                    rec_emit         = 1'b1;
                    rec.record_kind  = KIND_DATA;
                    rec.data_byte    = shifted;
                    rec.byte_index   = REG_WIDTH'(byte_count_reg);
                    rec.frame_length = '0;
                    rec.frame_status = STATUS_ACCEPTED;
                    byte_count_next  = byte_count_reg + COUNT_WIDTH'(1);
                end
            end

            // Run of ones, saturating.
            if (line_bit)
            begin
                ones_run_next = (ones_run_reg < RUN_SAT) ? ones_run_reg + 3'd1 : RUN_SAT;
            end
            else
            begin
                ones_run_next = '0;
            end
        end
    end

    // Output register and skid register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_rec_next    = out_rec_reg;
        skid_rec_next   = skid_rec_reg;

        if (out_xfer)
        begin
            out_valid_next = skid_valid_reg;
            out_rec_next   = skid_rec_reg;
            skid_valid_next = 1'b0;
        end

        if (rec_emit)
        begin
            if (!out_valid_reg || (out_xfer && !skid_valid_reg))
            begin
                out_valid_next = 1'b1;
                out_rec_next   = rec;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_rec_next   = rec;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ones_run_reg   <= '0;
            bit_count_reg  <= '0;
            byte_count_reg <= '0;
            shift_byte_reg <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            ones_run_reg   <= ones_run_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            shift_byte_reg <= shift_byte_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Record payload.
    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        skid_rec_reg <= skid_rec_next;
    end

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rec_reg.record_kind;
    assign m_axis_tdata  = {2'b00, out_rec_reg.frame_status, out_rec_reg.frame_length,
                            out_rec_reg.byte_index, out_rec_reg.data_byte};

    // The skid register is only filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid record held while output register is empty");

    // After a completed byte, m_axis_tvalid is always high on the next cycle.
    a_byte_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !run_full && !over_max && bit_count_reg == LAST_BIT) |=> m_axis_tvalid)
        else $error("completed byte not presented");

    // A frame end record never reports an empty frame.
    a_end_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rec_reg.record_kind == KIND_END)
            |-> (out_rec_reg.frame_length != '0))
        else $error("frame end record with zero length");

    // Data records carry no length or status.
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rec_reg.record_kind == KIND_DATA)
            |-> (out_rec_reg.frame_length == '0 && out_rec_reg.frame_status == STATUS_ACCEPTED))
        else $error("data record carries frame end fields");

endmodule
